### sv/ksp_pkg.sv
// Shared constants, codes and types for the key sequence prefix match table.
package ksp_pkg;

  // Default sizing
  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned PAIRS_DEF       = 4;

  // Fixed field widths
  localparam int unsigned IN_PAIRS   = 4;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned MODS_W     = 31;
  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned COUNT_OUT_W = 6;

  // Operation codes
  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_SEQ = 2'd1,
    OP_REMOVE_HND = 2'd2,
    OP_LOOKUP     = 2'd3
  } op_e;

  // Lookup result codes
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PARTIAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EQUAL   = 2'd2;

  // Compare result for one stored entry against the held query
  typedef struct packed {
    logic                equal;
    logic                partial;
    logic                same_slots;
    logic                handle_hit;
    logic [HANDLE_W-1:0] handle;
  } match_t;

endpackage

### sv/key_sequence_prefix_match_table_top.sv
// Key sequence table: insert, remove and prefix lookup over an entry memory.
// With the output free, an insert writes its row on accept if not full and
// goes through the finish state to result valid; remove and lookup first
// scan the held entries, one stored entry read from the memory per cycle.
// Throughput: one word at a time; the next word is taken once the sequencer
// is idle again, while the previous result may still wait at the output.
// Reset: asynchronous, empties the table (count to zero); no clearing pass.
module key_sequence_prefix_match_table_top #(
  parameter int unsigned TableDepth = ksp_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned Pairs      = ksp_pkg::PAIRS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        operation_i,
  input  logic [ksp_pkg::CODE_W-1:0]        first_code_i,
  input  logic [ksp_pkg::MODS_W-1:0]        first_mods_i,
  input  logic [ksp_pkg::CODE_W-1:0]        second_code_i,
  input  logic [ksp_pkg::MODS_W-1:0]        second_mods_i,
  input  logic [ksp_pkg::CODE_W-1:0]        third_code_i,
  input  logic [ksp_pkg::MODS_W-1:0]        third_mods_i,
  input  logic [ksp_pkg::CODE_W-1:0]        fourth_code_i,
  input  logic [ksp_pkg::MODS_W-1:0]        fourth_mods_i,
  input  logic [ksp_pkg::HANDLE_W-1:0]      handle_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ksp_pkg::KIND_W-1:0]        match_kind_o,
  output logic [ksp_pkg::HANDLE_W-1:0]      found_handle_o,
  output logic                              op_done_o,
  output logic                              table_full_o,
  output logic [ksp_pkg::COUNT_OUT_W-1:0]   entry_count_o
);
  import ksp_pkg::*;

  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned EntW  = Pairs * (CODE_W + MODS_W) + HANDLE_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  // Sequencer state
  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic [CntW-1:0] pend_idx_q, pend_idx_d;
  logic [CntW-1:0] pend_prev;
  logic            pend_q, pend_d;
  logic            hit_q, hit_d;
  logic            out_valid_q, out_valid_d;

  // Per-operation result state
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [HANDLE_W-1:0] found_q, found_d;
  logic                done_q, done_d;
  logic                full_q, full_d;

  // Held query
  op_e                          op_q;
  logic [Pairs-1:0][CODE_W-1:0] qc_q;
  logic [Pairs-1:0][MODS_W-1:0] qm_q;
  logic [HANDLE_W-1:0]          qh_q;

  // Output word
  logic [KIND_W-1:0]      res_kind_q;
  logic [HANDLE_W-1:0]    res_found_q;
  logic                   res_done_q;
  logic                   res_full_q;
  logic [COUNT_OUT_W-1:0] res_count_q;
  logic                   res_load;
  logic [CntW+COUNT_OUT_W-1:0] cnt_ext;

  // Memory and compare unit
  logic                         mem_we;
  logic [AddrW-1:0]             mem_waddr;
  logic [EntW-1:0]              mem_wdata;
  logic [AddrW-1:0]             mem_raddr;
  logic [EntW-1:0]              mem_rdata;
  logic [EntW-1:0]              ins_entry;
  match_t                       mres;
  logic                         accept;
  op_e                          in_op;

  logic [IN_PAIRS-1:0][CODE_W-1:0] in_codes;
  logic [IN_PAIRS-1:0][MODS_W-1:0] in_mods;
  logic [Pairs-1:0][CODE_W-1:0]    qry_codes;
  logic [Pairs-1:0][MODS_W-1:0]    qry_mods;

  assign in_codes = {fourth_code_i, third_code_i, second_code_i, first_code_i};
  assign in_mods  = {fourth_mods_i, third_mods_i, second_mods_i, first_mods_i};
  assign in_op    = op_e'(operation_i);

  // Fit the input pairs to the table's pair count; missing pairs read as zero
  for (genvar g = 0; g < Pairs; g++) begin : g_qry
    if (g < IN_PAIRS) begin : g_in
      assign qry_codes[g] = in_codes[g];
      assign qry_mods[g]  = in_mods[g];
    end else begin : g_zero
      assign qry_codes[g] = '0;
      assign qry_mods[g]  = '0;
    end
  end

  assign ins_entry  = {handle_i, qry_mods, qry_codes};
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign mem_raddr  = rd_cnt_q[AddrW-1:0];
  assign pend_prev  = pend_idx_q - CntW'(1);
  assign res_load   = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign cnt_ext    = {{COUNT_OUT_W{1'b0}}, count_q};

  ksp_mem #(
    .Depth (TableDepth),
    .Width (EntW),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ksp_match #(
    .Pairs (Pairs),
    .EntW  (EntW)
  ) u_match (
    .ent_i        (mem_rdata),
    .qry_codes_i  (qc_q),
    .qry_mods_i   (qm_q),
    .qry_handle_i (qh_q),
    .res_o        (mres)
  );

  // Sequencer: insert in one step, otherwise stream the entries; on a removal,
  // move every row after the removed one down by one
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_cnt_d    = rd_cnt_q;
    pend_d      = 1'b0;
    pend_idx_d  = rd_cnt_q;
    hit_d       = hit_q;
    kind_d      = kind_q;
    found_d     = found_q;
    done_d      = done_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = count_q[AddrW-1:0];
    mem_wdata   = ins_entry;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rd_cnt_d = '0;
          hit_d    = 1'b0;
          kind_d   = KIND_NONE;
          found_d  = '0;
          done_d   = 1'b0;
          full_d   = 1'b0;
          if (in_op == OP_INSERT) begin
            if (count_q >= CntW'(TableDepth)) begin
              full_d = 1'b1;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CntW'(1);
              done_d  = 1'b1;
            end
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read
        if (rd_cnt_q < count_q) begin
          pend_d   = 1'b1;
          rd_cnt_d = rd_cnt_q + CntW'(1);
        end
        // Check or move the row that just arrived
        if (pend_q) begin
          case (op_q)
            OP_REMOVE_SEQ, OP_REMOVE_HND: begin
              if (hit_q) begin
                mem_we    = 1'b1;
                mem_waddr = pend_prev[AddrW-1:0];
                mem_wdata = mem_rdata;
              end else if ((op_q == OP_REMOVE_SEQ) ? mres.same_slots
                                                   : mres.handle_hit) begin
                hit_d = 1'b1;
              end
            end
            OP_LOOKUP: begin
              if (kind_q != KIND_EQUAL) begin
                if (mres.equal) begin
                  kind_d  = KIND_EQUAL;
                  found_d = mres.handle;
                end else if (mres.partial) begin
                  kind_d = KIND_PARTIAL;
                end
              end
            end
            default: ;
          endcase
        end
        // All rows seen
        if (!pend_q && (rd_cnt_q >= count_q)) begin
          if (hit_q) begin
            count_d = count_q - CntW'(1);
            done_d  = 1'b1;
          end
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (res_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_cnt_q    <= rd_cnt_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    kind_q     <= kind_d;
    found_q    <= found_d;
    done_q     <= done_d;
    full_q     <= full_d;
    if (accept) begin
      op_q <= in_op;
      qc_q <= qry_codes;
      qm_q <= qry_mods;
      qh_q <= handle_i;
    end
    if (res_load) begin
      res_kind_q  <= kind_q;
      res_found_q <= found_q;
      res_done_q  <= done_q;
      res_full_q  <= full_q;
      res_count_q <= cnt_ext[COUNT_OUT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_kind_o   = res_kind_q;
  assign found_handle_o = res_found_q;
  assign op_done_o      = res_done_q;
  assign table_full_o   = res_full_q;
  assign entry_count_o  = res_count_q;

  // Checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("entry count above table depth");

  a_shift_after_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && mem_we) |-> hit_q)
    else $error("row moved before a removal hit");

  a_done_full_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(op_done_o && table_full_o))
    else $error("done and full reported together");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op == OP_INSERT && count_q < CntW'(TableDepth))
      |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the table");

  a_lookup_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && op_q == OP_LOOKUP) |-> !mem_we && !hit_q)
    else $error("lookup changed the table");

endmodule

### sv/ksp_mem.sv
// Entry memory: one write port, one read port, registered read data.
module ksp_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 284,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write the addressed row
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ksp_match.sv
// Compare unit: matches one stored entry against the held query.
module ksp_match #(
  parameter int unsigned Pairs = 4,
  parameter int unsigned EntW  = 284
) (
  input  logic [EntW-1:0]                     ent_i,
  input  logic [Pairs*ksp_pkg::CODE_W-1:0]    qry_codes_i,
  input  logic [Pairs*ksp_pkg::MODS_W-1:0]    qry_mods_i,
  input  logic [ksp_pkg::HANDLE_W-1:0]        qry_handle_i,
  output ksp_pkg::match_t                     res_o
);
  import ksp_pkg::*;

  localparam int unsigned LenW  = $clog2(Pairs + 1);
  localparam int unsigned CodeB = Pairs * CODE_W;
  localparam int unsigned ModsB = Pairs * MODS_W;

  logic [Pairs-1:0][CODE_W-1:0] ent_codes;
  logic [Pairs-1:0][MODS_W-1:0] ent_mods;
  logic [HANDLE_W-1:0]          ent_handle;
  logic [Pairs-1:0][CODE_W-1:0] q_codes;
  logic [Pairs-1:0][MODS_W-1:0] q_mods;
  logic [Pairs-1:0]             pair_eq;
  logic [LenW-1:0]              q_len;
  logic [LenW-1:0]              e_len;
  logic                         prefix_ok;

  // Unpack the stored row and the query
  assign ent_codes  = ent_i[CodeB-1:0];
  assign ent_mods   = ent_i[CodeB+ModsB-1:CodeB];
  assign ent_handle = ent_i[CodeB+ModsB+HANDLE_W-1:CodeB+ModsB];
  assign q_codes    = qry_codes_i;
  assign q_mods     = qry_mods_i;

  // Compare pairs and find both effective lengths
  always_comb begin
    q_len     = LenW'(Pairs);
    e_len     = LenW'(Pairs);
    prefix_ok = 1'b1;
    for (int i = Pairs - 1; i >= 0; i--) begin
      pair_eq[i] = (q_codes[i] == ent_codes[i]) && (q_mods[i] == ent_mods[i]);
      if (q_codes[i] == '0) begin
        q_len = LenW'(i);
      end
      if (ent_codes[i] == '0) begin
        e_len = LenW'(i);
      end
    end
    for (int i = 0; i < Pairs; i++) begin
      if ((LenW'(i) < q_len) && !pair_eq[i]) begin
        prefix_ok = 1'b0;
      end
    end
  end

  assign res_o.equal      = prefix_ok && (q_len == e_len);
  assign res_o.partial    = prefix_ok && (q_len < e_len);
  assign res_o.same_slots = &pair_eq;
  assign res_o.handle_hit = (ent_handle == qry_handle_i);
  assign res_o.handle     = ent_handle;

endmodule
